### hdl/btnm_pkg.sv
package btnm_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int COL_W  = $clog2(MAX_WIDTH);       // column index
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);   // effective width, 1..MAX_WIDTH
   localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);  // effective height
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);  // row position, runs to height + 1

   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int FW_BITS     = 11;
   localparam int FH_BITS     = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam int WIDTH_RESET  = 64;
   localparam int HEIGHT_RESET = 64;

   // item held between the input register and the window stage
   typedef struct packed {
      logic             cur;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } item_type;

   // window bit for column c (0 left .. 2 right), row r (0 top .. 2 bottom)
   function automatic int win_idx(input int c, input int r);
      return c * 3 + r;
   endfunction

   // neighbor mask; a_* say whether that side lies inside the frame
   function automatic logic [7:0] tile_mask_fn(
      input logic center,
      input logic tp, input logic trp, input logic rp, input logic brp,
      input logic bp, input logic blp, input logic lp, input logic tlp,
      input logic a_top, input logic a_bot, input logic a_left, input logic a_right);
      logic       t, r, b, l;
      logic [7:0] m;
      t = a_top & tp;
      r = a_right & rp;
      b = a_bot & bp;
      l = a_left & lp;
      m[0] = t;
      m[1] = t & r & trp;
      m[2] = r;
      m[3] = r & b & brp;
      m[4] = b;
      m[5] = b & l & blp;
      m[6] = l;
      m[7] = l & t & tlp;
      return center ? m : 8'd0;
   endfunction

endpackage

### hdl/btnm_row_store.sv
module btnm_row_store (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [btnm_pkg::COL_W-1:0] rd_addr,
   input  logic                      wr_en,
   input  logic [btnm_pkg::COL_W-1:0] wr_addr,
   input  logic [1:0]                wr_data,
   output logic [1:0]                rd_data
);
   import btnm_pkg::*;

   // bit 1: two rows back, bit 0: one row back
   logic [1:0] mem [MAX_WIDTH];
   logic [1:0] rd_ff;
   logic [1:0] byp_data_ff;
   logic       byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   // one-pixel rows read the entry written in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

### hdl/btnm_window.sv
module btnm_window (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       adv,
   input  btnm_pkg::item_type         item,
   input  logic [1:0]                 rd_data,
   input  logic [btnm_pkg::WID_W-1:0] width,
   input  logic [btnm_pkg::HGT_W-1:0] height,
   input  logic                       rsp_stall,
   output logic                       out_free,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_tile_mask,
   output logic                       rsp_last_of_frame
);
   import btnm_pkg::*;

   logic [8:0]       win_ff, win_in;
   logic             rsp_valid_ff;
   logic [7:0]       mask_ff, mask_in;
   logic             last_ff, last_in;
   logic             emit_in;
   logic             row_start, in_row;
   logic [ROW_W-1:0] h_row;

   assign h_row    = ROW_W'(height);
   assign win_in   = {item.cur, rd_data[0], rd_data[1], win_ff[8:3]};

   assign row_start = (item.col == '0) && (item.row >= ROW_W'(2));
   assign in_row    = (item.col != '0) && (item.row >= ROW_W'(1));

   always_comb begin
      emit_in = row_start || in_row;
      mask_in = 8'd0;
      last_in = 1'b0;
      if (row_start) begin
         // last pixel two rows back, before this item shifts in
         mask_in = tile_mask_fn(win_ff[win_idx(2, 1)],
            win_ff[win_idx(2, 0)], 1'b0, 1'b0, 1'b0,
            win_ff[win_idx(2, 2)], win_ff[win_idx(1, 2)],
            win_ff[win_idx(1, 1)], win_ff[win_idx(1, 0)],
            item.row >= ROW_W'(3), item.row <= h_row,
            width >= WID_W'(2), 1'b0);
         last_in = (item.row == h_row + ROW_W'(1));
      end else if (in_row) begin
         // right neighbor is the current item, always inside the frame
         mask_in = tile_mask_fn(win_in[win_idx(1, 1)],
            win_in[win_idx(1, 0)], win_in[win_idx(2, 0)],
            win_in[win_idx(2, 1)], win_in[win_idx(2, 2)],
            win_in[win_idx(1, 2)], win_in[win_idx(0, 2)],
            win_in[win_idx(0, 1)], win_in[win_idx(0, 0)],
            item.row >= ROW_W'(2), item.row < h_row,
            item.col >= COL_W'(2), 1'b1);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         win_ff <= '0;
      end else if (adv) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= adv && emit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && out_free) begin
         mask_ff <= mask_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tile_mask     = mask_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

### hdl/blob_tile_neighbor_mask.sv
// Streaming 8-neighbor tile mask over a binary raster.
// Request channel (req_valid / req_stall): one item per transfer, pixels in row
// order; req_op selects pixel or flush, req_is_white gives the pixel color.
// Response channel (rsp_valid / rsp_stall): tile mask of the pixel one row plus
// one pixel behind the current input, with rsp_last_of_frame on the final pixel.
// Items after the last row (flush items) drain the final row; width + 1 of them.
// Throughput: one item per clock while the response is not stalled. Each item
// sits in the input register (row store read) and then lands in the response
// register, from which its result is presented on the response channel.
// The 2-bit x MAX_WIDTH row store has one read and one write port per cycle.
// CSR writes (csr_we, csr_index, csr_wdata) set frame width / height and
// restart the frame; write only while the block is idle.
// Reset: synchronous; frame size back to 64 x 64, position and window cleared.
// Row store contents are not cleared; stale entries only feed out-of-frame sides.
// rsp_stall holds the response; the input register keeps taking one item
// while the response waits, then req_stall rises.
module blob_tile_neighbor_mask (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_op,
   input  logic                             req_is_white,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_tile_mask,
   output logic                             rsp_last_of_frame,
   input  logic                             csr_we,
   input  logic [btnm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [btnm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import btnm_pkg::*;

   logic [WID_W-1:0] frame_w_ff, frame_w_in;
   logic [HGT_W-1:0] frame_h_ff, frame_h_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WID_W-1:0] col_next;
   logic [ROW_W-1:0] h_row;
   logic [FW_BITS-1:0] fw_val;
   logic [FH_BITS-1:0] fh_val;
   item_type         item_ff;
   logic             item_valid_ff;
   logic             accept, adv, out_free;
   logic [1:0]       rd_data;

   assign accept = req_valid && !req_stall;
   assign adv    = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;

   // clamp register writes into range
   assign fw_val = csr_wdata[FW_BITS-1:0];
   assign fh_val = csr_wdata[FH_BITS-1:0];

   always_comb begin
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      unique case (csr_index)
         REG_FRAME_WIDTH: begin
            if (fw_val == '0) frame_w_in = WID_W'(1);
            else if (fw_val > FW_BITS'(MAX_WIDTH)) frame_w_in = WID_W'(MAX_WIDTH);
            else frame_w_in = WID_W'(fw_val);
         end
         REG_FRAME_HEIGHT: begin
            if (fh_val == '0) frame_h_in = HGT_W'(1);
            else if (fh_val > FH_BITS'(MAX_HEIGHT)) frame_h_in = HGT_W'(MAX_HEIGHT);
            else frame_h_in = HGT_W'(fh_val);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= WID_W'(WIDTH_RESET);
         frame_h_ff <= HGT_W'(HEIGHT_RESET);
      end else if (csr_we) begin
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
      end
   end

   // frame position of the next transfer
   assign h_row    = ROW_W'(frame_h_ff);
   assign col_next = WID_W'(col_ff) + WID_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (row_ff > h_row) begin
         col_in = '0;
         row_in = '0;
      end else if (col_next >= frame_w_ff) begin
         col_in = '0;
         row_in = row_ff + ROW_W'(1);
      end else begin
         col_in = col_next[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (accept) begin
         item_valid_ff <= 1'b1;
      end else if (adv) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.cur <= (req_op == OP_PIXEL) && (row_ff < h_row) && req_is_white;
         item_ff.col <= col_ff;
         item_ff.row <= row_ff;
      end
   end

   btnm_row_store u_row_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (adv),
      .wr_addr (item_ff.col),
      .wr_data ({rd_data[0], item_ff.cur}),
      .rd_data (rd_data)
   );

   btnm_window u_window (
      .clock             (clock),
      .reset             (reset),
      .clear             (csr_we),
      .adv               (adv),
      .item              (item_ff),
      .rd_data           (rd_data),
      .width             (frame_w_ff),
      .height            (frame_h_ff),
      .rsp_stall         (rsp_stall),
      .out_free          (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_tile_mask     (rsp_tile_mask),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

### test/blob_tile_neighbor_mask_test.sv
`timescale 1ns / 1ps

module blob_tile_neighbor_mask_test;
   import btnm_pkg::*;

   typedef struct {
      logic [7:0] mask;
      logic       last;
   } tile_result_type;

   class tile_mask_tracker_type;
      bit                 upper_row [MAX_WIDTH];
      bit                 lower_row [MAX_WIDTH];
      logic [8:0]         window;
      int unsigned        col_pos;
      int unsigned        row_pos;
      logic [FW_BITS-1:0] width_reg;
      logic [FH_BITS-1:0] height_reg;
      tile_result_type    due_masks [$];
      int                 errors;

      function new();
         window = '0;
         col_pos = 0;
         row_pos = 0;
         width_reg = FW_BITS'(WIDTH_RESET);
         height_reg = FH_BITS'(HEIGHT_RESET);
         errors = 0;
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH) return MAX_WIDTH;
         return 32'(width_reg);
      endfunction

      function int unsigned eff_height();
         if (height_reg == 0) return 1;
         if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
         return 32'(height_reg);
      endfunction

      // any write restarts the frame
      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_FRAME_WIDTH: width_reg = data[FW_BITS-1:0];
            REG_FRAME_HEIGHT: height_reg = data[FH_BITS-1:0];
            default: return;
         endcase
         window = '0;
         col_pos = 0;
         row_pos = 0;
      endfunction

      // c: 0 left .. 2 right, r: 0 top .. 2 bottom
      function bit win(int c, int r);
         if (c < 0 || c > 2 || r > 2) return 1'b0;
         return window[c * 3 + r];
      endfunction

      function logic [7:0] neighbor_mask(int mc, int unsigned cr, int unsigned cc,
                                         int unsigned w, int unsigned h);
         bit up, rt, dn, lf;
         if (!win(mc, 1)) return 8'd0;
         up = cr > 0 && win(mc, 0);
         dn = cr + 1 < h && win(mc, 2);
         lf = cc > 0 && mc > 0 && win(mc - 1, 1);
         rt = cc + 1 < w && win(mc + 1, 1);
         return {lf && up && win(mc - 1, 0), lf, dn && lf && win(mc - 1, 2), dn,
                 rt && dn && win(mc + 1, 2), rt, up && rt && win(mc + 1, 0), up};
      endfunction

      function void queue_mask(int mc, int unsigned cr, int unsigned cc,
                               int unsigned w, int unsigned h);
         tile_result_type res;
         res.mask = neighbor_mask(mc, cr, cc, w, h);
         res.last = (cr + 1 == h && cc + 1 == w);
         due_masks.push_back(res);
      endfunction

      function void take_item(logic op, logic white);
         int unsigned w, h, c, r;
         bit          cur;
         w = eff_width();
         h = eff_height();
         c = col_pos;
         r = row_pos;
         if (c >= w) c = 0;
         cur = (op == OP_PIXEL && r < h) ? white : 1'b0;
         // row start closes out the last pixel of two rows back
         if (c == 0 && r >= 2) queue_mask(2, r - 2, w - 1, w, h);
         window = {cur, lower_row[c], upper_row[c], window[8:3]};
         upper_row[c] = lower_row[c];
         lower_row[c] = cur;
         if (c >= 1 && r >= 1) queue_mask(1, r - 1, c - 1, w, h);
         if (r >= h + 1) begin
            col_pos = 0;
            row_pos = 0;
         end else begin
            c++;
            if (c >= w) begin
               c = 0;
               r++;
            end
            col_pos = c;
            row_pos = r;
         end
      endfunction

      function void match_mask(logic [7:0] mask, logic last);
         tile_result_type due;
         if (due_masks.size() == 0) begin
            $error("unexpected transfer: tile_mask %0d last_of_frame %0d", mask, last);
            errors++;
            return;
         end
         due = due_masks.pop_front();
         if (mask !== due.mask) begin
            $error("tile_mask: expected %0d, actual %0d", due.mask, mask);
            errors++;
         end
         if (last !== due.last) begin
            $error("last_of_frame: expected %0d, actual %0d", due.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_op;
   logic                   req_is_white;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [7:0]             rsp_tile_mask;
   logic                   rsp_last_of_frame;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tile_mask_tracker_type tracker = new();
   bit               calm = 1'b0;
   bit               hold_start = 1'b0;
   int               sent_items = 0;

   blob_tile_neighbor_mask DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_is_white(req_is_white),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tile_mask(rsp_tile_mask),
      .rsp_last_of_frame(rsp_last_of_frame),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 0;
   end

   task automatic push_item(input logic op, input logic white);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_is_white <= white;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_item(op, white);
      sent_items++;
   endtask

   // one full frame plus the drain run, at the current size
   task automatic run_frame(input int density);
      int unsigned w, h, i;
      logic        op;
      w = tracker.eff_width();
      h = tracker.eff_height();
      for (i = 0; i < w * h; i++) begin
         op = ($urandom_range(0, 15) == 0) ? OP_FLUSH : OP_PIXEL;
         push_item(op, $urandom_range(0, 99) < density);
      end
      for (i = 0; i <= w; i++) begin
         op = ($urandom_range(0, 9) == 0) ? OP_PIXEL : OP_FLUSH;
         push_item(op, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_stream(input int count, input int density);
      int   i;
      logic op;
      for (i = 0; i < count; i++) begin
         op = ($urandom_range(0, 9) == 0) ? OP_FLUSH : OP_PIXEL;
         push_item(op, $urandom_range(0, 99) < density);
      end
   endtask

   // wait until every due mask is out, then let the pipeline settle
   task automatic drain_block();
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.due_masks.size() != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_frame(input int unsigned wdata, input int unsigned hdata);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_FRAME_WIDTH;
      csr_wdata <= wdata[CSR_DATA_W-1:0];
      tracker.write_reg(REG_FRAME_WIDTH, wdata[CSR_DATA_W-1:0]);
      @(negedge clock);
      csr_index <= REG_FRAME_HEIGHT;
      csr_wdata <= hdata[CSR_DATA_W-1:0];
      tracker.write_reg(REG_FRAME_HEIGHT, hdata[CSR_DATA_W-1:0]);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // receiver: random stall, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 32);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_mask(rsp_tile_mask, rsp_last_of_frame);
   end

   initial begin
      #20_000_000;
      $display("blob_tile_neighbor_mask verification failed");
      $finish;
   end

   initial begin
      int          base;
      int unsigned wd, hd;
      int          nframes;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= OP_PIXEL;
      req_is_white <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= REG_FRAME_WIDTH;
      csr_wdata <= '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset size 64 x 64; results flow from row 1, then the receiver holds off
      run_stream(80, 60);
      hold_start = 1'b1;
      run_stream(70, 60);
      drain_block();

      // 3 x 2, all white: every diagonal present inside
      write_frame(3, 2);
      repeat (6) push_item(OP_PIXEL, 1'b1);
      repeat (4) push_item(OP_FLUSH, 1'b0);
      // flush inside the frame acts black; pixels in the drain run are ignored
      push_item(OP_PIXEL, 1'b1);
      push_item(OP_PIXEL, 1'b0);
      push_item(OP_PIXEL, 1'b1);
      push_item(OP_FLUSH, 1'b1);
      push_item(OP_PIXEL, 1'b1);
      push_item(OP_PIXEL, 1'b1);
      push_item(OP_PIXEL, 1'b1);
      push_item(OP_FLUSH, 1'b0);
      push_item(OP_FLUSH, 1'b1);
      push_item(OP_PIXEL, 1'b0);
      drain_block();

      // zero sizes act as a 1 x 1 frame
      write_frame(0, 0);
      push_item(OP_PIXEL, 1'b1);
      push_item(OP_PIXEL, 1'b1);
      push_item(OP_FLUSH, 1'b1);
      push_item(OP_FLUSH, 1'b0);
      push_item(OP_PIXEL, 1'b0);
      push_item(OP_FLUSH, 1'b1);
      drain_block();

      // sizes above the maximum clamp; stopped mid-frame, the next write restarts it
      write_frame(13'h1FFF, 13'h1FFF);
      run_stream(40, 60);
      drain_block();
      // back to back with no idling on either side
      write_frame(8, 8);
      calm = 1'b1;
      run_frame(80);
      calm = 1'b0;
      drain_block();

      base = sent_items;
      while (sent_items - base < 350) begin
         wd = $urandom_range(1, 9);
         if ($urandom_range(0, 7) == 0) wd = 0;
         hd = $urandom_range(1, 6);
         if ($urandom_range(0, 7) == 0) hd = 0;
         write_frame(($urandom_range(0, 3) << FW_BITS) | wd, hd);
         nframes = $urandom_range(1, 3);
         repeat (nframes) run_frame($urandom_range(25, 95));
         // sometimes stop mid-frame so the next write restarts it
         if ($urandom_range(0, 3) == 0) run_stream($urandom_range(1, 25), 60);
         drain_block();
      end

      if (tracker.due_masks.size() != 0) begin
         $error("%0d tile masks never arrived", tracker.due_masks.size());
         tracker.errors++;
      end
      if (tracker.errors == 0)
         $display("blob_tile_neighbor_mask verification clean");
      else
         $display("blob_tile_neighbor_mask verification failed");
      $finish;
   end

endmodule
